// ===== rtl/dram_fr_fcfs_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// DRAM FR-FCFS scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DRAM_FR_FCFS_SCHEDULER_DEFINES_SVH
`define DRAM_FR_FCFS_SCHEDULER_DEFINES_SVH

// Condition that must hold at every clock edge.
`define DFS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// DRAM FR-FCFS scheduler package
// Shared constants, codes, types and interval helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfs_pkg;

	localparam int BANK_COUNT      = 8;
	localparam int BANK_W          = 3;
	localparam int ROW_W           = 19;
	localparam int BANK_LSB        = 5;
	localparam int ROW_LSB         = 13;
	localparam int ADDR_W          = 32;
	localparam int CYC_W           = 32;
	localparam int TAG_W           = 4;
	localparam int BUSY_W          = 10;
	localparam int CMDC_W          = 8;
	localparam int XFER_W          = 10;
	localparam int RET_W           = 10;
	localparam int BMUL_W          = BUSY_W + 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 10;
	localparam int OCC_W           = 5;
	localparam int DEF_QUEUE_DEPTH = 16;

	localparam logic [BUSY_W-1:0] RST_BANK_BUSY = BUSY_W'(100);
	localparam logic [CMDC_W-1:0] RST_CMD_CYC   = CMDC_W'(4);
	localparam logic [XFER_W-1:0] RST_XFER_CYC  = XFER_W'(50);
	localparam logic [RET_W-1:0]  RST_RET_LAT   = RET_W'(20);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BANK_BUSY = 2'd0,
		REG_CMD_CYC   = 2'd1,
		REG_XFER_CYC  = 2'd2,
		REG_RET_LAT   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROW_HIT      = 2'd0,
		ROW_MISS     = 2'd1,
		ROW_CONFLICT = 2'd2
	} row_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_IVL,
		ST_BANK,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} dfs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              accept;
		logic              prep_mul;
		logic              prep_ivl;
		logic              bank_en;
		logic [BANK_W-1:0] bank_sel;
		logic              scan_rd;
		logic              finish;
	} dfs_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [CYC_W-1:0]  arrival;
		logic              from_mem;
		logic [TAG_W-1:0]  tag;
	} dfs_slot_t;

	// Two closed intervals do not overlap, by unsigned compare of the ends without wrap.
	function automatic logic disjoint(input logic [CYC_W-1:0] s0, input logic [CYC_W-1:0] e0,
		input logic [CYC_W-1:0] s1, input logic [CYC_W-1:0] e1);
		return (e0 < s1) || (s0 > e1);
	endfunction

endpackage

// ===== rtl/dram_fr_fcfs_scheduler.sv =====
// Sequence: an enqueue-only item goes from transfer straight to the issue step; a tick
// item passes precompute, bank pass, slot scan, drain and issue steps before its result.
// Throughput: the next item is taken in the cycle its predecessor's result is shown.
// Tick length comes from the serial pass over the eight banks and the one-slot-per-cycle
// scan through the queue memory read port. Results cannot be stalled by the receiver.
// Reset: queue empty, all banks closed, registers at their default values; no sweep.
// ----------------------------------------------------------------------------
// DRAM FR-FCFS scheduler top level
// Joins the sequencing controller and the queue and bank datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dram_fr_fcfs_scheduler import dfs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic [CYC_W-1:0]      cycle_now,
	input  logic                  new_valid,
	input  logic [ADDR_W-1:0]     new_address,
	input  logic                  new_from_mem,
	input  logic [TAG_W-1:0]      new_tag,
	output logic                  done,
	output logic                  issued,
	output logic [TAG_W-1:0]      issued_tag,
	output logic [BANK_W-1:0]     issued_bank,
	output logic [1:0]            row_status,
	output logic [CYC_W-1:0]      fill_cycle,
	output logic                  enqueue_dropped,
	output logic [OCC_W-1:0]      occupancy
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	dfs_cmd_t         cmd;
	logic [IDX_W-1:0] scan_idx;

	// Sequencer.
	dfs_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.busy    (busy),
		.cmd     (cmd),
		.scan_idx(scan_idx)
	);

	// Queue, bank state and pick logic.
	dfs_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.IDX_W      (IDX_W)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.scan_idx       (scan_idx),
		.cycle_now      (cycle_now),
		.new_valid      (new_valid),
		.new_address    (new_address),
		.new_from_mem   (new_from_mem),
		.new_tag        (new_tag),
		.done           (done),
		.issued         (issued),
		.issued_tag     (issued_tag),
		.issued_bank    (issued_bank),
		.row_status     (row_status),
		.fill_cycle     (fill_cycle),
		.enqueue_dropped(enqueue_dropped),
		.occupancy      (occupancy)
	);

endmodule

// ===== rtl/dfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// DRAM FR-FCFS scheduler controller
// Sequences enqueue, resource precompute, bank pass, slot scan and issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dram_fr_fcfs_scheduler_defines.svh"

module dfs_ctrl import dfs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             req_type,
	output logic             busy,
	output dfs_cmd_t         cmd,
	output logic [IDX_W-1:0] scan_idx
);

	dfs_state_t        state_q, state_d;
	logic [BANK_W-1:0] bank_cnt_q;
	logic [IDX_W-1:0]  scan_cnt_q;

	// State register and step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bank_cnt_q <= '0;
			scan_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			bank_cnt_q <= (state_q == ST_BANK) ? bank_cnt_q + BANK_W'(1) : '0;
			scan_cnt_q <= (state_q == ST_SCAN) ? scan_cnt_q + IDX_W'(1) : '0;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.bank_sel = bank_cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = req_type ? ST_MUL : ST_FIN;
				end
			end
			ST_MUL: begin
				cmd.prep_mul = 1'b1;
				state_d      = ST_IVL;
			end
			ST_IVL: begin
				cmd.prep_ivl = 1'b1;
				state_d      = ST_BANK;
			end
			ST_BANK: begin
				cmd.bank_en = 1'b1;
				if (bank_cnt_q == BANK_W'(BANK_COUNT - 1)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (scan_cnt_q == IDX_W'(QUEUE_DEPTH - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign scan_idx = scan_cnt_q;

	`DFS_ASSERT_NEXT(a_fin_to_idle, cmd.finish, !busy, "issue step not followed by idle")
	`DFS_ASSERT_NEXT(a_accept_busy, cmd.accept, busy, "accepted item did not make the block busy")

endmodule

// ===== rtl/dfs_datapath.sv =====
// ----------------------------------------------------------------------------
// DRAM FR-FCFS scheduler datapath
// Request queue, bank state, conflict precompute, FR-FCFS pick and issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dram_fr_fcfs_scheduler_defines.svh"

module dfs_datapath import dfs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int IDX_W       = $clog2(QUEUE_DEPTH),
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  dfs_cmd_t              cmd,
	input  logic [IDX_W-1:0]      scan_idx,
	input  logic [CYC_W-1:0]      cycle_now,
	input  logic                  new_valid,
	input  logic [ADDR_W-1:0]     new_address,
	input  logic                  new_from_mem,
	input  logic [TAG_W-1:0]      new_tag,
	output logic                  done,
	output logic                  issued,
	output logic [TAG_W-1:0]      issued_tag,
	output logic [BANK_W-1:0]     issued_bank,
	output logic [1:0]            row_status,
	output logic [CYC_W-1:0]      fill_cycle,
	output logic                  enqueue_dropped,
	output logic [OCC_W-1:0]      occupancy
);

	// Configuration registers.
	logic [BUSY_W-1:0] busy_cyc_q;
	logic [CMDC_W-1:0] cmd_cyc_q;
	logic [XFER_W-1:0] xfer_cyc_q;
	logic [RET_W-1:0]  ret_lat_q;

	// Queue state.
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	dfs_slot_t              slot_mem [QUEUE_DEPTH];
	dfs_slot_t              rd_q;
	logic [IDX_W-1:0]       idx_s1;
	logic                   eval_s1;
	logic [CYC_W-1:0]       now_q;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;

	// Bank state.
	logic              bk_open_q  [BANK_COUNT];
	logic [ROW_W-1:0]  bk_row_q   [BANK_COUNT];
	logic [CYC_W-1:0]  bk_start_q [BANK_COUNT];
	logic [1:0]        bk_cnt_q   [BANK_COUNT];

	// Precomputed intervals and conflict flags.
	logic [BMUL_W-1:0] bmul_q [0:3];
	logic [CYC_W-1:0]  cs_q [0:2];
	logic [CYC_W-1:0]  ce_q [0:2];
	logic [CYC_W-1:0]  ds_q [1:3];
	logic [CYC_W-1:0]  de_q [1:3];
	logic [2:0]        cmd_conf_q;
	logic [3:1]        data_conf_q;
	logic [3:1]        self_conf_q [BANK_COUNT];
	logic [2:0]        cmd_hit;
	logic [3:1]        data_hit;
	logic [3:1]        self_hit;

	// Best candidate so far.
	logic              best_v_q;
	logic              best_hit_q;
	logic [CYC_W-1:0]  best_arr_q;
	logic              best_mem_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [TAG_W-1:0]  best_tag_q;
	logic [BANK_W-1:0] best_bank_q;
	logic [ROW_W-1:0]  best_row_q;
	row_status_t       best_rs_q;

	// Result registers.
	logic              done_q;
	logic              issued_q;
	logic [TAG_W-1:0]  issued_tag_q;
	logic [BANK_W-1:0] issued_bank_q;
	logic [1:0]        row_status_q;
	logic [CYC_W-1:0]  fill_q;
	logic              drop_q;

	// Candidate evaluation signals.
	logic [BANK_W-1:0] ev_bank;
	logic [ROW_W-1:0]  ev_row;
	row_status_t       ev_rs;
	logic [1:0]        ev_n;
	logic              ev_hit;
	logic              ev_ok;
	logic              ev_cand;
	logic              ev_take;
	logic [1:0]        fin_n;

	// Lowest free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Slot payload memory: one write port at transfer, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (cmd.accept && new_valid && free_found) begin
			slot_mem[free_idx] <= '{addr: new_address, arrival: cycle_now,
				from_mem: new_from_mem, tag: new_tag};
		end
		if (cmd.scan_rd) rd_q <= slot_mem[scan_idx];
	end

	// Conflicts of one bank's recorded run against the candidate intervals.
	always_comb begin
		logic [BANK_W-1:0] u;
		logic [CYC_W-1:0]  st, ss, se, ts, te;
		u        = cmd.bank_sel;
		st       = bk_start_q[u];
		cmd_hit  = '0;
		data_hit = '0;
		self_hit = '0;
		for (int j = 0; j < 3; j++) begin
			ss = st + CYC_W'(bmul_q[j]);
			se = ss + CYC_W'(cmd_cyc_q) - CYC_W'(1);
			for (int k = 0; k < 3; k++) begin
				if (bk_open_q[u] && (2'(j) < bk_cnt_q[u]) &&
					!disjoint(cs_q[k], ce_q[k], ss, se)) cmd_hit[k] = 1'b1;
			end
		end
		ts = st + CYC_W'(bmul_q[bk_cnt_q[u]]);
		te = ts + CYC_W'(xfer_cyc_q) - CYC_W'(1);
		for (int n = 1; n <= 3; n++) begin
			data_hit[n] = bk_open_q[u] && !disjoint(ds_q[n], de_q[n], ts, te);
			self_hit[n] = bk_open_q[u] &&
				!disjoint(now_q, ds_q[n] - CYC_W'(1), st, ts - CYC_W'(1));
		end
	end

	// Scan candidate: row state, resource check and FR-FCFS order.
	always_comb begin
		ev_bank = rd_q.addr[BANK_LSB +: BANK_W];
		ev_row  = rd_q.addr[ROW_LSB +: ROW_W];
		if (!bk_open_q[ev_bank]) ev_rs = ROW_MISS;
		else if (bk_row_q[ev_bank] == ev_row) ev_rs = ROW_HIT;
		else ev_rs = ROW_CONFLICT;
		ev_n    = 2'(ev_rs) + 2'd1;
		ev_hit  = (ev_rs == ROW_HIT);
		ev_ok   = !(cmd_conf_q[0] || (ev_n >= 2'd2 && cmd_conf_q[1]) ||
			(ev_n == 2'd3 && cmd_conf_q[2]) || data_conf_q[ev_n] ||
			self_conf_q[ev_bank][ev_n]);
		ev_cand = eval_s1 && valid_q[idx_s1] && !(now_q < rd_q.arrival) && ev_ok;
		ev_take = ev_cand && (!best_v_q || (ev_hit && !best_hit_q) ||
			((ev_hit == best_hit_q) && ((rd_q.arrival < best_arr_q) ||
			((rd_q.arrival == best_arr_q) && rd_q.from_mem && !best_mem_q))));
		fin_n   = 2'(best_rs_q) + 2'd1;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cyc_q <= RST_BANK_BUSY;
			cmd_cyc_q  <= RST_CMD_CYC;
			xfer_cyc_q <= RST_XFER_CYC;
			ret_lat_q  <= RST_RET_LAT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_BANK_BUSY: busy_cyc_q <= cfg_wdata[BUSY_W-1:0];
				REG_CMD_CYC:   cmd_cyc_q  <= cfg_wdata[CMDC_W-1:0];
				REG_XFER_CYC:  xfer_cyc_q <= cfg_wdata[XFER_W-1:0];
				REG_RET_LAT:   ret_lat_q  <= cfg_wdata[RET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Queue control, bank state, pick and issue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			eval_s1     <= 1'b0;
			best_v_q    <= 1'b0;
			done_q      <= 1'b0;
			issued_q    <= 1'b0;
			drop_q      <= 1'b0;
			cmd_conf_q  <= '0;
			data_conf_q <= '0;
			for (int b = 0; b < BANK_COUNT; b++) begin
				bk_open_q[b]   <= 1'b0;
				bk_row_q[b]    <= '0;
				bk_start_q[b]  <= '0;
				bk_cnt_q[b]    <= '0;
				self_conf_q[b] <= '0;
			end
		end else begin
			eval_s1 <= cmd.scan_rd;
			idx_s1  <= scan_idx;
			done_q  <= cmd.finish;

			// Transfer of an item: enqueue its miss and start a fresh pick.
			if (cmd.accept) begin
				now_q    <= cycle_now;
				best_v_q <= 1'b0;
				drop_q   <= new_valid && !free_found;
				if (new_valid && free_found) begin
					valid_q[free_idx] <= 1'b1;
					count_q           <= count_q + CNT_W'(1);
				end
			end

			// Multiples of the bank busy time.
			if (cmd.prep_mul) begin
				bmul_q[0]   <= '0;
				bmul_q[1]   <= BMUL_W'(busy_cyc_q);
				bmul_q[2]   <= BMUL_W'(busy_cyc_q) << 1;
				bmul_q[3]   <= BMUL_W'(busy_cyc_q) + (BMUL_W'(busy_cyc_q) << 1);
				cmd_conf_q  <= '0;
				data_conf_q <= '0;
			end

			// Candidate command and transfer intervals.
			if (cmd.prep_ivl) begin
				for (int k = 0; k < 3; k++) begin
					cs_q[k] <= now_q + CYC_W'(bmul_q[k]);
					ce_q[k] <= now_q + CYC_W'(bmul_q[k]) + CYC_W'(cmd_cyc_q) - CYC_W'(1);
				end
				for (int n = 1; n <= 3; n++) begin
					ds_q[n] <= now_q + CYC_W'(bmul_q[n]);
					de_q[n] <= now_q + CYC_W'(bmul_q[n]) + CYC_W'(xfer_cyc_q) - CYC_W'(1);
				end
			end

			// One bank per cycle.
			if (cmd.bank_en) begin
				cmd_conf_q                <= cmd_conf_q | cmd_hit;
				data_conf_q               <= data_conf_q | data_hit;
				self_conf_q[cmd.bank_sel] <= self_hit;
			end

			// One slot per cycle.
			if (ev_take) begin
				best_v_q    <= 1'b1;
				best_hit_q  <= ev_hit;
				best_arr_q  <= rd_q.arrival;
				best_mem_q  <= rd_q.from_mem;
				best_idx_q  <= idx_s1;
				best_tag_q  <= rd_q.tag;
				best_bank_q <= ev_bank;
				best_row_q  <= ev_row;
				best_rs_q   <= ev_rs;
			end

			// Issue the pick and form the result.
			if (cmd.finish) begin
				issued_q <= best_v_q;
				if (best_v_q) begin
					valid_q[best_idx_q]     <= 1'b0;
					count_q                 <= count_q - CNT_W'(1);
					bk_open_q[best_bank_q]  <= 1'b1;
					bk_row_q[best_bank_q]   <= best_row_q;
					bk_start_q[best_bank_q] <= now_q;
					bk_cnt_q[best_bank_q]   <= fin_n;
					issued_tag_q            <= best_tag_q;
					issued_bank_q           <= best_bank_q;
					row_status_q            <= 2'(best_rs_q);
					fill_q                  <= ds_q[fin_n] + CYC_W'(xfer_cyc_q) +
						CYC_W'(ret_lat_q);
				end else begin
					issued_tag_q  <= '0;
					issued_bank_q <= '0;
					row_status_q  <= '0;
					fill_q        <= '0;
				end
			end
		end
	end

	assign done            = done_q;
	assign issued          = issued_q;
	assign issued_tag      = issued_tag_q;
	assign issued_bank     = issued_bank_q;
	assign row_status      = row_status_q;
	assign fill_cycle      = fill_q;
	assign enqueue_dropped = drop_q;
	assign occupancy       = OCC_W'(count_q);

	`DFS_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
	`DFS_ASSERT_ALWAYS(a_best_live, !best_v_q || issued_q || valid_q[best_idx_q], "pick not valid")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// FR-FCFS DRAM scheduler testbench
// Sends directed and random enqueue and tick transfers to the scheduler. A
// local scoreboard of the request queue and the bank timing predicts each
// result, which is then checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import dfs_pkg::*;

	localparam int DEPTH     = 16;
	localparam int CYC_LIMIT = 600000;
	localparam int SETTLE    = 40;

	typedef struct {
		logic        tick;
		logic [31:0] now;
		logic        valid;
		logic [31:0] addr;
		logic        from_mem;
		logic [3:0]  tag;
	} req_t;

	typedef struct {
		logic        issued;
		logic [3:0]  tag;
		logic [2:0]  bank;
		logic [1:0]  rstat;
		logic [31:0] fill;
		logic        dropped;
		logic [4:0]  occ;
	} sched_res_t;

	typedef struct {
		req_t       req;
		bit         typed;
		sched_res_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  start;
	logic                  busy;
	logic                  req_type;
	logic [31:0]           cycle_now;
	logic                  new_valid;
	logic [31:0]           new_address;
	logic                  new_from_mem;
	logic [3:0]            new_tag;
	logic                  done;
	logic                  issued;
	logic [3:0]            issued_tag;
	logic [2:0]            issued_bank;
	logic [1:0]            row_status;
	logic [31:0]           fill_cycle;
	logic                  enqueue_dropped;
	logic [4:0]            occupancy;

	dram_fr_fcfs_scheduler #(.QUEUE_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy), .req_type(req_type),
		.cycle_now(cycle_now), .new_valid(new_valid), .new_address(new_address),
		.new_from_mem(new_from_mem), .new_tag(new_tag), .done(done), .issued(issued),
		.issued_tag(issued_tag), .issued_bank(issued_bank), .row_status(row_status),
		.fill_cycle(fill_cycle), .enqueue_dropped(enqueue_dropped),
		.occupancy(occupancy)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Scheduler timing registers as seen by the scoreboard.
	logic [9:0]  bank_hold;
	logic [7:0]  cmd_hold;
	logic [9:0]  xfer_hold;
	logic [9:0]  ret_lat;

	// Scoreboard copy of the request queue and the bank state.
	logic        q_valid [DEPTH];
	logic [31:0] q_addr [DEPTH];
	logic [31:0] q_arrival [DEPTH];
	logic        q_mem [DEPTH];
	logic [3:0]  q_tag [DEPTH];
	logic        b_open [8];
	logic [18:0] b_row [8];
	logic [31:0] b_start [8];
	logic [1:0]  b_cmds [8];
	int          q_count;

	sched_res_t  pending_q[$];
	int          mismatches;
	int          n_items;
	int          n_issued;
	int          n_dropped;
	int          cyc_count;
	int          idle_pct;

	function automatic row_status_t row_kind(logic [31:0] a);
		logic [2:0] b;
		b = a[7:5];
		if (!b_open[b])
			return ROW_MISS;
		return (b_row[b] == a[31:13]) ? ROW_HIT : ROW_CONFLICT;
	endfunction

	function automatic bit overlaps(logic [31:0] s0, logic [31:0] e0, logic [31:0] s1,
		logic [31:0] e1);
		return !((e0 < s1) || (s0 > e1));
	endfunction

	// Command bus, data bus and bank occupancy checks for one candidate.
	function automatic bit can_schedule(logic [31:0] a, logic [31:0] now);
		logic [2:0]  b;
		logic [31:0] n, cs, ce, ss, se, ds, de, ts, te, busy32;
		b = a[7:5];
		n = 32'(row_kind(a)) + 32'd1;
		busy32 = 32'(bank_hold);
		for (int k = 0; k < n; k++) begin
			cs = now + 32'(k) * busy32;
			ce = cs + 32'(cmd_hold) - 32'd1;
			for (int u = 0; u < 8; u++) begin
				if (!b_open[u])
					continue;
				for (int j = 0; j < b_cmds[u]; j++) begin
					ss = b_start[u] + 32'(j) * busy32;
					se = ss + 32'(cmd_hold) - 32'd1;
					if (overlaps(cs, ce, ss, se))
						return 1'b0;
				end
			end
		end
		ds = now + n * busy32;
		de = ds + 32'(xfer_hold) - 32'd1;
		for (int u = 0; u < 8; u++) begin
			if (!b_open[u])
				continue;
			ts = b_start[u] + 32'(b_cmds[u]) * busy32;
			te = ts + 32'(xfer_hold) - 32'd1;
			if (overlaps(ds, de, ts, te))
				return 1'b0;
		end
		if (b_open[b]) begin
			se = b_start[b] + 32'(b_cmds[b]) * busy32 - 32'd1;
			if (overlaps(now, now + n * busy32 - 32'd1, b_start[b], se))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Enqueue, then pick and issue by FR-FCFS on a tick.
	task automatic predict_schedule(input req_t r, output sched_res_t res);
		int          best;
		bit          best_hit, hit, placed;
		logic [31:0] a;
		logic [2:0]  b;
		logic [31:0] n;
		res = '{default: '0};
		if (r.valid) begin
			placed = 1'b0;
			for (int i = 0; i < DEPTH && !placed; i++) begin
				if (q_valid[i])
					continue;
				q_valid[i] = 1'b1;
				q_addr[i] = r.addr;
				q_arrival[i] = r.now;
				q_mem[i] = r.from_mem;
				q_tag[i] = r.tag;
				q_count++;
				placed = 1'b1;
			end
			res.dropped = !placed;
		end
		if (r.tick) begin
			best = -1;
			best_hit = 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				if (!q_valid[i] || r.now < q_arrival[i])
					continue;
				if (!can_schedule(q_addr[i], r.now))
					continue;
				hit = (row_kind(q_addr[i]) == ROW_HIT);
				if (best < 0) begin
					best = i;
					best_hit = hit;
				end else if (hit != best_hit) begin
					if (hit) begin
						best = i;
						best_hit = 1'b1;
					end
				end else if (q_arrival[i] < q_arrival[best]) begin
					best = i;
				end else if (q_arrival[i] == q_arrival[best] && q_mem[i] && !q_mem[best]) begin
					best = i;
				end
			end
			if (best >= 0) begin
				a = q_addr[best];
				b = a[7:5];
				res.rstat = row_kind(a);
				n = 32'(res.rstat) + 32'd1;
				b_cmds[b] = n[1:0];
				b_start[b] = r.now;
				b_open[b] = 1'b1;
				b_row[b] = a[31:13];
				res.fill = r.now + n * 32'(bank_hold) + 32'(xfer_hold) + 32'(ret_lat);
				res.issued = 1'b1;
				res.tag = q_tag[best];
				res.bank = b;
				q_valid[best] = 1'b0;
				q_count--;
			end
		end
		res.occ = q_count[4:0];
	endtask

	// One transfer into the block; the typed value replaces the prediction when given.
	task automatic send_req(input req_t r, input bit typed, input sched_res_t want);
		sched_res_t got;
		req_type = r.tick;
		cycle_now = r.now;
		new_valid = r.valid;
		new_address = r.addr;
		new_from_mem = r.from_mem;
		new_tag = r.tag;
		start = 1'b1;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		predict_schedule(r, got);
		if (typed)
			pending_q.push_back(want);
		else
			pending_q.push_back(got);
		n_items++;
		@(negedge clk);
		start = 1'b0;
		if ($urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, 8)) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [9:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		case (idx)
			REG_BANK_BUSY: bank_hold = val;
			REG_CMD_CYC:   cmd_hold = val[7:0];
			REG_XFER_CYC:  xfer_hold = val;
			REG_RET_LAT:   ret_lat = val;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0)
			@(negedge clk);
	endtask

	// Random requests: mostly a small pool of rows so hits and conflicts occur.
	task automatic random_phase(input int count, input logic [31:0] stride);
		req_t        r;
		logic [31:0] clock_pos;
		sched_res_t  none;
		int          sel;
		none = '{default: '0};
		clock_pos = $urandom();
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel <= 2)
				clock_pos = $urandom();
			else if (sel <= 4)
				clock_pos = 32'hFFFF_FFFF - $urandom_range(300);
			else if (sel <= 7)
				clock_pos = clock_pos - $urandom_range(stride);
			else
				clock_pos = clock_pos + $urandom_range(stride);
			r.now = clock_pos;
			r.tick = ($urandom_range(99) < 70);
			r.valid = ($urandom_range(99) < 65);
			r.addr = $urandom();
			if ($urandom_range(99) < 85)
				r.addr[31:13] = 19'($urandom_range(3));
			r.from_mem = $urandom_range(1);
			r.tag = $urandom_range(15);
			send_req(r, 1'b0, none);
		end
	endtask

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		sched_res_t exp_r;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: tag %0d occ %0d", issued_tag, occupancy);
			end else begin
				exp_r = pending_q.pop_front();
				n_issued += exp_r.issued;
				n_dropped += exp_r.dropped;
				if (issued !== exp_r.issued || issued_tag !== exp_r.tag ||
					issued_bank !== exp_r.bank || row_status !== exp_r.rstat ||
					fill_cycle !== exp_r.fill || enqueue_dropped !== exp_r.dropped ||
					occupancy !== exp_r.occ) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: exp iss %0d tag %0d bank %0d rs %0d fill %h",
							exp_r.issued, exp_r.tag, exp_r.bank, exp_r.rstat, exp_r.fill);
						$write(" drop %0d occ %0d", exp_r.dropped, exp_r.occ);
						$display(" / got %0d %0d %0d %0d %h %0d %0d",
							issued, issued_tag, issued_bank, row_status, fill_cycle,
							enqueue_dropped, occupancy);
					end
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count > CYC_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t  rows[$];
		stim_row_t  row;
		sched_res_t none;
		int         wait_cyc;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_BANK_BUSY;
		cfg_wdata = '0;
		start = 1'b0;
		req_type = 1'b0;
		cycle_now = '0;
		new_valid = 1'b0;
		new_address = '0;
		new_from_mem = 1'b0;
		new_tag = '0;
		mismatches = 0;
		n_items = 0;
		n_issued = 0;
		n_dropped = 0;
		cyc_count = 0;
		idle_pct = 10;
		none = '{default: '0};
		bank_hold = 10'd100;
		cmd_hold = 8'd4;
		xfer_hold = 10'd50;
		ret_lat = 10'd20;
		q_count = 0;
		for (int i = 0; i < DEPTH; i++)
			q_valid[i] = 1'b0;
		for (int u = 0; u < 8; u++) begin
			b_open[u] = 1'b0;
			b_row[u] = '0;
			b_start[u] = '0;
			b_cmds[u] = '0;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty tick, first miss, full queue, cycle extremes.
		row = '{req: '{1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 4'd0}, typed: 1'b1, want: none};
		rows.push_back(row);
		row.req = '{1'b0, 32'd10, 1'b1, 32'h0000_0000, 1'b0, 4'd15};
		row.want.occ = 5'd1;
		rows.push_back(row);
		row.req = '{1'b1, 32'd10, 1'b0, 32'd0, 1'b0, 4'd0};
		row.want = '{1'b1, 4'd15, 3'd0, ROW_MISS, 32'd280, 1'b0, 5'd0};
		rows.push_back(row);
		for (int i = 0; i < DEPTH; i++) begin
			row.req = '{1'b0, 32'd1000, 1'b1, {19'(i % 3), 5'h00, 3'(i), 5'h1F}, 1'(i),
				4'(15 - i)};
			row.typed = 1'b0;
			rows.push_back(row);
		end
		row.req = '{1'b0, 32'd1000, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd7};
		row.typed = 1'b1;
		row.want = '{1'b0, 4'd0, 3'd0, ROW_HIT, 32'd0, 1'b1, 5'd16};
		rows.push_back(row);
		row.typed = 1'b0;
		row.req = '{1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 4'd0};
		rows.push_back(row);
		row.req = '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 4'd0};
		rows.push_back(row);
		row.req = '{1'b1, 32'd1010, 1'b0, 32'd0, 1'b0, 4'd0};
		rows.push_back(row);
		row.req = '{1'b1, 32'd2000, 1'b0, 32'd0, 1'b0, 4'd0};
		rows.push_back(row);
		foreach (rows[i])
			send_req(rows[i].req, rows[i].typed, rows[i].want);
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		// Sender idles after about one request in ten.
		idle_pct = 10;
		write_reg(REG_BANK_BUSY, 10'd1);
		write_reg(REG_CMD_CYC, 10'd1);
		write_reg(REG_XFER_CYC, 10'd1);
		write_reg(REG_RET_LAT, 10'd0);
		random_phase(330, 32'd6);
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		// Sender idles often.
		idle_pct = 46;
		write_reg(REG_BANK_BUSY, 10'd1023);
		write_reg(REG_CMD_CYC, 10'd255);
		write_reg(REG_XFER_CYC, 10'd1023);
		write_reg(REG_RET_LAT, 10'd1023);
		random_phase(330, 32'd3000);
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		// No idling from here on.
		idle_pct = 0;
		write_reg(REG_BANK_BUSY, 10'($urandom_range(2, 40)));
		write_reg(REG_CMD_CYC, 10'($urandom_range(1, 8)));
		write_reg(REG_XFER_CYC, 10'($urandom_range(1, 30)));
		write_reg(REG_RET_LAT, 10'($urandom_range(1023)));
		random_phase(360, 32'd60);
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		// Zero lengths wrap interval ends below their starts.
		write_reg(REG_BANK_BUSY, 10'd0);
		write_reg(REG_CMD_CYC, 10'd0);
		write_reg(REG_XFER_CYC, 10'd0);
		random_phase(300, 32'd4);
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		write_reg(REG_BANK_BUSY, 10'd100);
		write_reg(REG_CMD_CYC, 10'd4);
		write_reg(REG_XFER_CYC, 10'd50);
		write_reg(REG_RET_LAT, 10'd20);
		random_phase(410, 32'd120);

		wait_cyc = 0;
		while (pending_q.size() != 0 && wait_cyc < 5000) begin
			@(negedge clk);
			wait_cyc++;
		end
		repeat (SETTLE) @(negedge clk);

		$display("Sent %0d requests over five timing settings; %0d issued, %0d dropped.",
			n_items, n_issued, n_dropped);
		$display("Mismatches: %0d, results still pending: %0d.", mismatches, pending_q.size());
		if (mismatches == 0 && pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
